### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/ulcm_pkg.sv
// shared types, constants and keyword table for the line command matcher
`timescale 1ns / 1ps

package ulcm_pkg;

    localparam int LINE_LEN   = 40;
    localparam int LINE_SLOTS = 20;
    localparam int KW_COUNT   = 8;
    localparam int KW_MAX_LEN = 16;
    localparam int KW_BITS    = KW_MAX_LEN * 8;

    localparam int POS_W  = $clog2(LINE_LEN + 1);
    localparam int SLOT_W = $clog2(LINE_SLOTS + 1);
    localparam int CODE_W = 4;
    localparam int OSLOT_W = 5;
    localparam int KLEN_W = $clog2(KW_MAX_LEN + 1);
    localparam int KIDX_W = $clog2(KW_MAX_LEN);

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [CODE_W-1:0] CODE_NONE = CODE_W'(KW_COUNT);

    // keyword text, right aligned: first character in the highest used byte
    localparam logic [KW_BITS-1:0] KW_STR [KW_COUNT] = '{
        KW_BITS'({"led_", "all_on"}),
        KW_BITS'({"led_", "all_off"}),
        KW_BITS'({"led_", "on_down"}),
        KW_BITS'({"led_", "on_up"}),
        KW_BITS'({"flower", "_on"}),
        KW_BITS'({"flower", "_off"}),
        KW_BITS'({"led_", "keep_on_up"}),
        KW_BITS'({"led_", "keep_on_down"})
    };

    localparam logic [KLEN_W-1:0] KW_LEN [KW_COUNT] = '{
        KLEN_W'(10), KLEN_W'(11), KLEN_W'(11), KLEN_W'(9),
        KLEN_W'(9), KLEN_W'(10), KLEN_W'(14), KLEN_W'(16)
    };

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [SLOT_W-1:0]   slot;
        logic [KW_COUNT-1:0] alive;
    } ulcm_state_t;

    typedef struct packed {
        logic                 valid;
        logic [CODE_W-1:0]    code;
        logic [OSLOT_W-1:0]   slot;
    } ulcm_result_t;

    // character of keyword k at a position known to lie inside the keyword
    function automatic logic [7:0] kw_char(input int k, input logic [POS_W-1:0] pos);
        logic [KIDX_W-1:0] idx;
        idx = KIDX_W'(KW_LEN[k] - KLEN_W'(1) - KLEN_W'(pos));
        return KW_STR[k][idx*8 +: 8];
    endfunction

endpackage

### rtl/ulcm_step.sv
// next-state and result logic for one received byte
`timescale 1ns / 1ps

module ulcm_step import ulcm_pkg::*;
(
    input  ulcm_state_t  cur,
    input  logic [7:0]   rx_byte,
    output ulcm_state_t  nxt,
    output ulcm_result_t res
);

    logic [KW_COUNT-1:0] mismatch;
    logic [KW_COUNT-1:0] done;
    logic [CODE_W-1:0]   code;
    logic                term;

    assign term = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            mismatch[k] = (KLEN_W'(cur.pos) < KW_LEN[k]) && (cur.pos < POS_W'(KW_MAX_LEN))
                          && (rx_byte != kw_char(k, cur.pos));
            done[k] = cur.alive[k] && (cur.pos >= POS_W'(KW_LEN[k]));
        end
    end

    // first keyword in table order wins
    always_comb
    begin
        code = CODE_NONE;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (done[k])
            begin
                code = CODE_W'(k);
            end
        end
    end

    always_comb
    begin
        nxt = cur;
        res.valid = 1'b0;
        res.code  = code;
        res.slot  = OSLOT_W'(cur.slot);
        if (cur.slot >= SLOT_W'(LINE_SLOTS))
        begin
            nxt.slot = '0;
        end
        else if (cur.pos >= POS_W'(LINE_LEN))
        begin
            nxt.pos   = '0;
            nxt.alive = '1;
        end
        else if (term)
        begin
            res.valid = 1'b1;
            nxt.pos   = '0;
            nxt.alive = '1;
            nxt.slot  = cur.slot + SLOT_W'(1);
        end
        else
        begin
            nxt.alive = cur.alive & ~mismatch;
            nxt.pos   = cur.pos + POS_W'(1);
        end
    end

endmodule

### rtl/uart_line_command_matcher_core.sv
// top level of the line command matcher: input stage, state and result register
//
// channel   dir  beat contents
// s_axis    in   rx_byte[7:0]
// m_axis    out  match_code[3:0], line_slot[8:4], zero pad
//
// one byte per cycle unless m_axis stalls; each beat comes via the input and result registers
// one beat per accepted cr or lf but not at a full line or slot wrap; none for other bytes
// state updates in the second stage from the registered byte
// a stall holds the state and a full input stage; s_axis_tready drops only when both are full
// rst_n clears position, slot counter and both valid flags and sets the alive mask
`timescale 1ns / 1ps

module uart_line_command_matcher_core import ulcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // match_code[3:0], line_slot[8:4], zero [15:9]
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    ulcm_state_t  state_reg;
    ulcm_state_t  state_next;
    ulcm_result_t res_next;
    logic         out_valid_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic [OSLOT_W-1:0] out_slot_reg;
    logic         advance;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    ulcm_step u_step
    (
        .cur     (state_reg),
        .rx_byte (in_byte_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.pos   <= '0;
            state_reg.slot  <= '0;
            state_reg.alive <= '1;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg && res_next.valid;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && in_valid_reg && res_next.valid)
        begin
            out_code_reg <= res_next.code;
            out_slot_reg <= res_next.slot;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_slot_reg, out_code_reg};

endmodule

### rtl/ulcm_checker.sv
// port-level checks for the line command matcher, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ulcm_checker import ulcm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic slot_ok;
    assign slot_ok = (m_axis_tdata[8:4] < OSLOT_W'(LINE_SLOTS)) && (m_axis_tdata[15:9] == 7'd0);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `ASSERT_SAME(a_code_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[3:0] <= CODE_NONE)
    `ASSERT_SAME(a_slot_range, clk, rst_n, m_axis_tvalid, slot_ok)
    `ASSERT_SAME(a_ready_free, clk, rst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind uart_line_command_matcher_core ulcm_checker u_ulcm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
